// ===== design/ttx_utf8_pkg.sv =====
// Package for the teletext cell to UTF-8 text converter.
// Holds the result item type, code point constants and the cell mapping functions.
// No dependencies.
`timescale 1ns / 1ps

package ttx_utf8_pkg;

  localparam int CP_W      = 21;
  localparam int NL_W      = 5;
  localparam int SP_W      = 6;
  localparam int MAX_RES   = 7;
  localparam int RES_CNT_W = 3;

  localparam logic [NL_W-1:0] NL_MAX = '1;
  localparam logic [SP_W-1:0] SP_MAX = '1;

  localparam logic [7:0] BYTE_NEWLINE = 8'h0A;
  localparam logic [7:0] BYTE_SPACE   = 8'h20;

  localparam logic [CP_W-1:0] CP_BLANK        = 21'h00000;
  localparam logic [CP_W-1:0] CP_SPACE        = 21'h00020;
  localparam logic [CP_W-1:0] CP_SEXTANT_BASE = 21'h1FB00;
  localparam logic [CP_W-1:0] CP_LEFT_HALF    = 21'h0258C;
  localparam logic [CP_W-1:0] CP_RIGHT_HALF   = 21'h02590;
  localparam logic [CP_W-1:0] CP_FULL_BLOCK   = 21'h02588;
  localparam logic [CP_W-1:0] CP_POUND        = 21'h000A3;
  localparam logic [CP_W-1:0] CP_ARROW_LEFT   = 21'h02190;
  localparam logic [CP_W-1:0] CP_ONE_HALF     = 21'h000BD;
  localparam logic [CP_W-1:0] CP_ARROW_RIGHT  = 21'h02192;
  localparam logic [CP_W-1:0] CP_ARROW_UP     = 21'h02191;
  localparam logic [CP_W-1:0] CP_HASH         = 21'h00023;
  localparam logic [CP_W-1:0] CP_HORIZ_BAR    = 21'h02015;
  localparam logic [CP_W-1:0] CP_ONE_QUARTER  = 21'h000BC;
  localparam logic [CP_W-1:0] CP_DOUBLE_BAR   = 21'h02016;
  localparam logic [CP_W-1:0] CP_THREE_QUART  = 21'h000BE;
  localparam logic [CP_W-1:0] CP_DIVIDE       = 21'h000F7;

  localparam logic [5:0] PAT_EMPTY = 6'h00;
  localparam logic [5:0] PAT_LEFT  = 6'h15;
  localparam logic [5:0] PAT_RIGHT = 6'h2A;
  localparam logic [5:0] PAT_FULL  = 6'h3F;

  typedef enum logic {
    REG_DISPLAYED_READING = 1'b0,
    REG_FLOWED_LINES      = 1'b1
  } cfg_reg_t;

  typedef enum logic {
    KIND_BYTES = 1'b0,
    KIND_END   = 1'b1
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    logic [5:0] rep;
    logic       last;
  } res_t;

  function automatic logic [CP_W-1:0] mosaic_cp(input logic [7:0] ch);
    logic [5:0] pat;
    logic [1:0] skip;
    logic [CP_W-1:0] cp;
    pat  = {ch[6], ch[4:0]};
    skip = {1'b0, (pat > PAT_LEFT)} + {1'b0, (pat > PAT_RIGHT)};
    case (pat)
      PAT_EMPTY: cp = CP_SPACE;
      PAT_LEFT:  cp = CP_LEFT_HALF;
      PAT_RIGHT: cp = CP_RIGHT_HALF;
      PAT_FULL:  cp = CP_FULL_BLOCK;
      default:   cp = CP_SEXTANT_BASE + {15'd0, pat} - 21'd1 - {19'd0, skip};
    endcase
    return cp;
  endfunction

  function automatic logic [CP_W-1:0] alpha_cp(input logic [7:0] ch, input logic disp);
    logic [CP_W-1:0] cp;
    if (ch >= 8'h20 && ch < 8'h7F) cp = {13'd0, ch};
    else cp = CP_BLANK;
    if (disp) begin
      case (ch)
        8'h23:   cp = CP_POUND;
        8'h5B:   cp = CP_ARROW_LEFT;
        8'h5C:   cp = CP_ONE_HALF;
        8'h5D:   cp = CP_ARROW_RIGHT;
        8'h5E:   cp = CP_ARROW_UP;
        8'h5F:   cp = CP_HASH;
        8'h60:   cp = CP_HORIZ_BAR;
        8'h7B:   cp = CP_ONE_QUARTER;
        8'h7C:   cp = CP_DOUBLE_BAR;
        8'h7D:   cp = CP_THREE_QUART;
        8'h7E:   cp = CP_DIVIDE;
        default: ;
      endcase
    end
    return cp;
  endfunction

endpackage

// ===== design/teletext_cells_to_utf8_text.sv =====
// Teletext cell stream to UTF-8 text: the input register feeds the result buffer, which
// holds the results of one cell (up to 7) and shifts them out; one cell per cycle while
// each cell gives at most one result and out_tready is high; a cell with more results holds
// the next cell in the input register until its last result is taken.
// Synchronous active-low reset: pending newline and space counts clear, displayed
// reading set, flowed lines cleared, input and result buffers empty.
// Depends on ttx_utf8_pkg.
`timescale 1ns / 1ps

module teletext_cells_to_utf8_text
  import ttx_utf8_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] cell_char
  input  logic [4:0]  in_tuser,   // [0] is_graphics, [1] concealed, [2] double_bottom,
                                  // [3] is_control, [4] row_end
  input  logic        in_tlast,   // region_end
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] out_byte, [13:8] repeat_res, [15:14] zero
  output logic        out_tuser,  // kind
  output logic        out_tlast,  // last
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic        cfg_wdata
);

  logic            disp_r, flow_r;
  logic [NL_W-1:0] nl_r, nl_nxt;
  logic [SP_W-1:0] sp_r, sp_nxt;

  logic       in_v_r;
  logic [7:0] ch_r;
  logic [4:0] flags_r;
  logic       gend_r;

  res_t                 buf_r [MAX_RES];
  logic [RES_CNT_W-1:0] cnt_r;

  logic take, buf_free, move;

  assign out_tvalid = (cnt_r != '0);
  assign out_tdata  = {2'b00, buf_r[0].rep, buf_r[0].data};
  assign out_tuser  = buf_r[0].kind;
  assign out_tlast  = buf_r[0].last;

  assign take      = out_tvalid && out_tready;
  assign buf_free  = (cnt_r == '0) || (take && cnt_r == RES_CNT_W'(1));
  assign move      = in_v_r && buf_free;
  assign in_tready = !in_v_r || move;

  logic            gfx, conc, dbot, ctrl, rend;
  logic [CP_W-1:0] cp;
  logic            blank;
  logic [2:0]      ulen;
  logic [7:0]      ub [4];
  res_t            lst [MAX_RES];
  logic [RES_CNT_W-1:0] n;

  always_comb begin
    gfx  = flags_r[0];
    conc = flags_r[1];
    dbot = flags_r[2];
    ctrl = flags_r[3];
    rend = flags_r[4];

    if (conc || dbot) cp = CP_BLANK;
    else if (gfx && ch_r[5]) cp = disp_r ? mosaic_cp(ch_r) : CP_BLANK;
    else if (ctrl) cp = CP_BLANK;
    else cp = alpha_cp(ch_r, disp_r);

    blank = (cp == CP_BLANK) || (cp == CP_SPACE);

    if (cp < 21'h80) begin
      ulen = 3'd1;
      ub[0] = cp[7:0];
      ub[1] = 8'h00;
      ub[2] = 8'h00;
      ub[3] = 8'h00;
    end else if (cp < 21'h800) begin
      ulen = 3'd2;
      ub[0] = {3'b110, cp[10:6]};
      ub[1] = {2'b10, cp[5:0]};
      ub[2] = 8'h00;
      ub[3] = 8'h00;
    end else if (cp < 21'h10000) begin
      ulen = 3'd3;
      ub[0] = {4'b1110, cp[15:12]};
      ub[1] = {2'b10, cp[11:6]};
      ub[2] = {2'b10, cp[5:0]};
      ub[3] = 8'h00;
    end else begin
      ulen = 3'd4;
      ub[0] = {5'b11110, cp[20:18]};
      ub[1] = {2'b10, cp[17:12]};
      ub[2] = {2'b10, cp[11:6]};
      ub[3] = {2'b10, cp[5:0]};
    end

    for (int k = 0; k < MAX_RES; k++) lst[k] = '0;
    n = '0;
    nl_nxt = nl_r;
    sp_nxt = sp_r;

    if (!blank) begin
      if (nl_r != '0) begin
        lst[n] = '{kind: KIND_BYTES, data: BYTE_NEWLINE, rep: {1'b0, nl_r}, last: 1'b0};
        n = n + RES_CNT_W'(1);
      end
      if (sp_r != '0) begin
        lst[n] = '{kind: KIND_BYTES, data: BYTE_SPACE, rep: sp_r, last: 1'b0};
        n = n + RES_CNT_W'(1);
      end
      for (int k = 0; k < 4; k++) begin
        if (3'(k) < ulen) begin
          lst[n] = '{kind: KIND_BYTES, data: ub[k], rep: 6'd1, last: 1'b0};
          n = n + RES_CNT_W'(1);
        end
      end
      nl_nxt = '0;
      sp_nxt = '0;
    end else if (sp_r != SP_MAX) begin
      sp_nxt = sp_r + SP_W'(1);
    end

    if (rend || gend_r) begin
      sp_nxt = '0;
      if ((!flow_r || blank) && nl_nxt != NL_MAX) nl_nxt = nl_nxt + NL_W'(1);
    end

    if (gend_r) begin
      nl_nxt = '0;
      sp_nxt = '0;
      lst[n] = '{kind: KIND_END, data: 8'h00, rep: 6'd0, last: 1'b0};
      n = n + RES_CNT_W'(1);
    end

    for (int k = 0; k < MAX_RES; k++) lst[k].last = (RES_CNT_W'(k + 1) == n);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      disp_r <= 1'b1;
      flow_r <= 1'b0;
      nl_r   <= '0;
      sp_r   <= '0;
      in_v_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_DISPLAYED_READING: disp_r <= cfg_wdata;
          REG_FLOWED_LINES:      flow_r <= cfg_wdata;
          default: ;
        endcase
      end

      if (in_tready) in_v_r <= in_tvalid;

      if (move) begin
        nl_r  <= nl_nxt;
        sp_r  <= sp_nxt;
        cnt_r <= n;
      end else if (take) begin
        cnt_r <= cnt_r - RES_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      ch_r    <= in_tdata;
      flags_r <= in_tuser;
      gend_r  <= in_tlast;
    end
    if (move) begin
      for (int k = 0; k < MAX_RES; k++) buf_r[k] <= lst[k];
    end else if (take) begin
      for (int k = 0; k < MAX_RES - 1; k++) buf_r[k] <= buf_r[k+1];
    end
  end

endmodule
